// File: src/ssx_pkg.sv
`timescale 1ns / 1ps
package ssx_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_ELEMS_DEF  = 64;
  localparam int ELEM_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int OFS_W     = 17;  // slice offsets and step
  localparam int IDX_W     = 18;  // signed index arithmetic, one bit of headroom
  localparam int VAL_W     = 32;  // item and result value
  localparam int CFG_IDX_W = 3;

  // UTF-8 continuation bytes carry 10 in the top two bits
  localparam logic [7:0] CONT_MASK = 8'b1100_0000;
  localparam logic [7:0] CONT_CODE = 8'b1000_0000;

  typedef enum logic [1:0] {
    CMD_ELEM   = 2'd0,
    CMD_EMPTY  = 2'd1,
    CMD_NULL   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEGIN_OFFSET = 3'd0,
    CFG_BEGIN_GIVEN  = 3'd1,
    CFG_END_OFFSET   = 3'd2,
    CFG_END_GIVEN    = 3'd3,
    CFG_STEP         = 3'd4,
    CFG_UTF8_MODE    = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    JOB_SLICE = 1'b0,
    JOB_NULL  = 1'b1
  } job_kind_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [VAL_W-1:0] item_value;
    logic             row_end;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] out_value;
    logic             out_last;
    logic             slice_empty;
    logic             null_result;
    logic             truncated;
  } out_item_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] begin_offset;
    logic                    begin_given;
    logic signed [OFS_W-1:0] end_offset;
    logic                    end_given;
    logic signed [OFS_W-1:0] step;
    logic                    utf8_mode;
  } cfg_t;

  typedef struct packed {
    job_kind_t kind;
    logic      overflow;
  } job_t;

endpackage

// File: src/ssx_buffer.sv
`timescale 1ns / 1ps
module ssx_buffer #(
  parameter int MAX_ELEMS  = ssx_pkg::MAX_ELEMS_DEF,
  parameter int ELEM_WIDTH = ssx_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          elem_we,
  input  logic [$clog2(MAX_ELEMS)-1:0]  elem_waddr,
  input  logic [ELEM_WIDTH-1:0]         elem_wdata,
  input  logic                          elem_rd_en,
  input  logic [$clog2(MAX_ELEMS)-1:0]  elem_rd_addr,
  output logic [ELEM_WIDTH-1:0]         elem_rd_data,
  input  logic                          cps_we,
  input  logic [$clog2(MAX_ELEMS)-1:0]  cps_waddr,
  input  logic [$clog2(MAX_ELEMS)-1:0]  cps_wdata,
  input  logic [$clog2(MAX_ELEMS)-1:0]  cps_rd_addr0,
  input  logic [$clog2(MAX_ELEMS)-1:0]  cps_rd_addr1,
  output logic [$clog2(MAX_ELEMS)-1:0]  cps_rd_data0,
  output logic [$clog2(MAX_ELEMS)-1:0]  cps_rd_data1
);
  import ssx_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);

  logic [ELEM_WIDTH-1:0] elem_mem [MAX_ELEMS];
  logic [AW-1:0]         cps_mem  [MAX_ELEMS];
  logic [ELEM_WIDTH-1:0] elem_rd_r;
  logic [AW-1:0]         cps_rd0_r;
  logic [AW-1:0]         cps_rd1_r;

  // Element bytes or list elements: one write, one registered read
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    if (elem_rd_en) begin
      elem_rd_r <= elem_mem[elem_rd_addr];
    end
  end

  // Code point starts: one write, two registered reads (start and next start)
  always_ff @(posedge clk) begin
    if (cps_we) begin
      cps_mem[cps_waddr] <= cps_wdata;
    end
    cps_rd0_r <= cps_mem[cps_rd_addr0];
    cps_rd1_r <= cps_mem[cps_rd_addr1];
  end

  assign elem_rd_data = elem_rd_r;
  assign cps_rd_data0 = cps_rd0_r;
  assign cps_rd_data1 = cps_rd1_r;

endmodule

// File: src/ssx_front.sv
`timescale 1ns / 1ps
module ssx_front #(
  parameter int MAX_ELEMS  = ssx_pkg::MAX_ELEMS_DEF,
  parameter int ELEM_WIDTH = ssx_pkg::ELEM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  ssx_pkg::in_item_t              in_item,
  input  logic                           utf8_mode,
  output logic                           elem_we,
  output logic [$clog2(MAX_ELEMS)-1:0]   elem_waddr,
  output logic [ELEM_WIDTH-1:0]          elem_wdata,
  output logic                           cps_we,
  output logic [$clog2(MAX_ELEMS)-1:0]   cps_waddr,
  output logic [$clog2(MAX_ELEMS)-1:0]   cps_wdata,
  output logic                           job_push,
  output ssx_pkg::job_t                  job,
  output logic [$clog2(MAX_ELEMS+1)-1:0] job_ecnt,
  output logic [$clog2(MAX_ELEMS+1)-1:0] job_cpc
);
  import ssx_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);

  logic [CW-1:0] ecnt_r, ecnt_nxt;
  logic [CW-1:0] cpc_r,  cpc_nxt;
  logic          ovf_r,  ovf_nxt;
  logic          room;
  logic          cp_room;
  logic          cp_begin;

  assign room       = ecnt_r < CW'(MAX_ELEMS);
  assign cp_room    = cpc_r < CW'(MAX_ELEMS);
  assign cp_begin   = (in_item.item_value[7:0] & CONT_MASK) != CONT_CODE;
  assign elem_waddr = ecnt_r[AW-1:0];
  assign elem_wdata = utf8_mode ? ELEM_WIDTH'(in_item.item_value[7:0])
                                : ELEM_WIDTH'(in_item.item_value);
  assign cps_waddr  = cpc_r[AW-1:0];
  assign cps_wdata  = ecnt_r[AW-1:0];

  always_comb begin
    ecnt_nxt = ecnt_r;
    cpc_nxt  = cpc_r;
    ovf_nxt  = ovf_r;
    elem_we  = 1'b0;
    cps_we   = 1'b0;
    job_push = 1'b0;
    job      = '{kind: JOB_SLICE, overflow: 1'b0};
    job_ecnt = ecnt_r;
    job_cpc  = cpc_r;
    if (accept) begin
      unique case (in_item.cmd)
        CMD_ELEM: begin
          if (room) begin
            elem_we  = 1'b1;
            ecnt_nxt = ecnt_r + 1'b1;
            if (utf8_mode && cp_begin && cp_room) begin
              cps_we  = 1'b1;
              cpc_nxt = cpc_r + 1'b1;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item.row_end) begin
            job_push     = 1'b1;
            job.overflow = ovf_nxt;
            job_ecnt     = ecnt_nxt;
            job_cpc      = cpc_nxt;
            ecnt_nxt     = '0;
            cpc_nxt      = '0;
            ovf_nxt      = 1'b0;
          end
        end
        CMD_EMPTY: begin
          job_push = 1'b1;
          job_ecnt = '0;
          job_cpc  = '0;
          ecnt_nxt = '0;
          cpc_nxt  = '0;
          ovf_nxt  = 1'b0;
        end
        CMD_NULL: begin
          job_push = 1'b1;
          job.kind = JOB_NULL;
          ecnt_nxt = '0;
          cpc_nxt  = '0;
          ovf_nxt  = 1'b0;
        end
        CMD_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r <= '0;
      cpc_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      ecnt_r <= ecnt_nxt;
      cpc_r  <= cpc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

// File: src/ssx_queue.sv
`timescale 1ns / 1ps
module ssx_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          not_empty,
  output logic          full
);
  import ssx_pkg::*;

  logic [DW-1:0] mem_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          do_push;
  logic          do_pop;

  assign not_empty = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: src/ssx_back.sv
`timescale 1ns / 1ps
module ssx_back #(
  parameter int MAX_ELEMS  = ssx_pkg::MAX_ELEMS_DEF,
  parameter int ELEM_WIDTH = ssx_pkg::ELEM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ssx_pkg::cfg_t                  cfg,
  input  logic                           job_valid,
  input  ssx_pkg::job_t                  job,
  input  logic [$clog2(MAX_ELEMS+1)-1:0] job_ecnt,
  input  logic [$clog2(MAX_ELEMS+1)-1:0] job_cpc,
  output logic                           job_pop,
  output logic                           elem_rd_en,
  output logic [$clog2(MAX_ELEMS)-1:0]   elem_rd_addr,
  input  logic [ELEM_WIDTH-1:0]          elem_rd_data,
  output logic [$clog2(MAX_ELEMS)-1:0]   cps_rd_addr0,
  output logic [$clog2(MAX_ELEMS)-1:0]   cps_rd_addr1,
  input  logic [$clog2(MAX_ELEMS)-1:0]   cps_rd_data0,
  input  logic [$clog2(MAX_ELEMS)-1:0]   cps_rd_data1,
  output logic                           back_busy,
  output logic                           out_valid,
  output ssx_pkg::out_item_t             out_item
);
  import ssx_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b000_0001,
    S_SETUP   = 7'b000_0010,
    S_CLAMP   = 7'b000_0100,
    S_NEXT    = 7'b000_1000,
    S_CP_WAIT = 7'b001_0000,
    S_BYTES   = 7'b010_0000,
    S_FINISH  = 7'b100_0000
  } state_t;

  state_t                   state_r,   state_nxt;
  logic [CW-1:0]            ecnt_r,    ecnt_nxt;
  logic [CW-1:0]            cpc_r,     cpc_nxt;
  logic                     ovf_r,     ovf_nxt;
  job_kind_t                kind_r,    kind_nxt;
  logic signed [IDX_W-1:0]  first_r,   first_nxt;
  logic signed [IDX_W-1:0]  last_r,    last_nxt;
  logic [CW-1:0]            lo_r,      lo_nxt;
  logic [CW-1:0]            hi_r,      hi_nxt;
  logic signed [IDX_W-1:0]  idx_r,     idx_nxt;
  logic                     cp_last_r, cp_last_nxt;
  logic [CW-1:0]            b_r,       b_nxt;
  logic [CW-1:0]            to_r,      to_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic [VAL_W-1:0]         held_r,    held_nxt;
  logic                     held_valid_r, held_valid_nxt;
  logic                     out_valid_r,  out_valid_nxt;
  out_item_t                out_item_r,   out_item_nxt;

  logic [CW-1:0]            len;
  logic signed [IDX_W-1:0]  len_s;
  logic signed [IDX_W-1:0]  step_s;
  logic signed [IDX_W-1:0]  first_a;
  logic signed [IDX_W-1:0]  last_a;
  logic signed [IDX_W-1:0]  lo_s;
  logic signed [IDX_W-1:0]  hi_s;
  logic [CW-1:0]            lo_c;
  logic [CW-1:0]            hi_c;
  logic                     step_err;
  logic                     fwd;
  logic                     in_rng;

  assign len      = cfg.utf8_mode ? cpc_r : ecnt_r;
  assign len_s    = $signed(IDX_W'(len));
  assign step_s   = IDX_W'(cfg.step);
  assign step_err = (cfg.step == '0) || (cfg.utf8_mode && cfg.step[OFS_W-1]);
  assign fwd      = !step_s[IDX_W-1];
  assign first_a  = cfg.begin_given ? IDX_W'(cfg.begin_offset) : $signed(IDX_W'(0));
  assign last_a   = cfg.end_given ? IDX_W'(cfg.end_offset) : len_s;

  // Clamp the adjusted bounds to [0, len]
  assign lo_c = first_r[IDX_W-1] ? '0 : ((first_r > len_s) ? len : first_r[CW-1:0]);
  assign hi_c = last_r[IDX_W-1]  ? '0 : ((last_r  > len_s) ? len : last_r[CW-1:0]);
  assign lo_s = $signed(IDX_W'(lo_r));
  assign hi_s = $signed(IDX_W'(hi_r));
  assign in_rng = fwd ? (idx_r < hi_s) : (idx_r >= lo_s);

  assign cps_rd_addr0 = idx_r[AW-1:0];
  assign cps_rd_addr1 = idx_r[AW-1:0] + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    ecnt_nxt       = ecnt_r;
    cpc_nxt        = cpc_r;
    ovf_nxt        = ovf_r;
    kind_nxt       = kind_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    idx_nxt        = idx_r;
    cp_last_nxt    = cp_last_r;
    b_nxt          = b_r;
    to_nxt         = to_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    job_pop        = 1'b0;
    elem_rd_en     = 1'b0;
    elem_rd_addr   = idx_r[AW-1:0];

    // Data back from the buffer: push the held result out, hold the new one
    if (rd_pend_r) begin
      if (held_valid_r) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{out_value: held_r, out_last: 1'b0, slice_empty: 1'b0,
                          null_result: 1'b0, truncated: ovf_r};
      end
      held_nxt       = VAL_W'(elem_rd_data);
      held_valid_nxt = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          ecnt_nxt  = job_ecnt;
          cpc_nxt   = job_cpc;
          ovf_nxt   = job.overflow;
          kind_nxt  = job.kind;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (kind_r == JOB_NULL || step_err) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{out_value: '0, out_last: 1'b1, slice_empty: 1'b0,
                            null_result: 1'b1,
                            truncated: (kind_r == JOB_NULL) ? 1'b0 : ovf_r};
          state_nxt     = S_IDLE;
        end else begin
          first_nxt = first_a[IDX_W-1] ? first_a + len_s : first_a;
          last_nxt  = last_a[IDX_W-1]  ? last_a + len_s  : last_a;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        lo_nxt = lo_c;
        hi_nxt = hi_c;
        if (hi_c > lo_c) begin
          idx_nxt   = fwd ? $signed(IDX_W'(lo_c)) : $signed(IDX_W'(hi_c - 1'b1));
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_NEXT: begin
        if (!in_rng) begin
          state_nxt = S_FINISH;
        end else if (cfg.utf8_mode) begin
          cp_last_nxt = (idx_r[CW-1:0] + 1'b1) == cpc_r;
          idx_nxt     = idx_r + step_s;
          state_nxt   = S_CP_WAIT;
        end else begin
          elem_rd_en = 1'b1;
          idx_nxt    = idx_r + step_s;
        end
      end
      S_CP_WAIT: begin
        b_nxt     = CW'(cps_rd_data0);
        to_nxt    = cp_last_r ? ecnt_r : CW'(cps_rd_data1);
        state_nxt = S_BYTES;
      end
      S_BYTES: begin
        elem_rd_addr = b_r[AW-1:0];
        if (b_r < to_r) begin
          elem_rd_en = 1'b1;
          b_nxt      = b_r + 1'b1;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_FINISH: begin
        if (!rd_pend_r) begin
          out_valid_nxt = 1'b1;
          if (held_valid_r) begin
            out_item_nxt = '{out_value: held_r, out_last: 1'b1, slice_empty: 1'b0,
                             null_result: 1'b0, truncated: ovf_r};
          end else begin
            out_item_nxt = '{out_value: '0, out_last: 1'b1, slice_empty: 1'b1,
                             null_result: 1'b0, truncated: ovf_r};
          end
          held_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_pend_nxt = elem_rd_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_pend_r    <= 1'b0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_pend_r    <= rd_pend_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ecnt_r     <= ecnt_nxt;
    cpc_r      <= cpc_nxt;
    ovf_r      <= ovf_nxt;
    kind_r     <= kind_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    idx_r      <= idx_nxt;
    cp_last_r  <= cp_last_nxt;
    b_r        <= b_nxt;
    to_r       <= to_nxt;
    held_r     <= held_nxt;
    out_item_r <= out_item_nxt;
  end

  assign back_busy = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rd_pend_r && !held_valid_r))
    else $error("read or held result left over after a row finished");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    elem_rd_en |=> (state_r != S_IDLE))
    else $error("buffer read issued with no row in progress to take it");

  a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && !rd_pend_r) |=> (out_valid_r && out_item_r.out_last))
    else $error("row closed without a final result");

endmodule

// File: src/strided_slice_extractor_top.sv
`timescale 1ns / 1ps
// Strided slice extractor.
// Input channel (start/busy, in_item): a transaction is taken at a rising edge with
// start high and busy low. cmd ELEM loads one element (or one UTF-8 byte in string
// mode) into the row buffer, one per cycle while busy is low; row_end closes the row.
// cmd EMPTY closes an empty row, cmd NULL drops the partial row and gives a null result,
// the unused code is ignored.
// Result channel (out_valid, out_item): each result transaction is shown for one
// cycle; the receiver cannot stall it. The row's final result carries out_last.
// Configuration (cfg_we, cfg_index, cfg_wdata): one register per write, no wait.
// Loading runs at one element per cycle while busy is low; elements past MAX_ELEMS
// are dropped and flag the row's results truncated. A list slice streams one element
// per cycle; a string slice does a start-table lookup per code point, then one buffer
// read per byte. busy stays high from the closing transaction until the back end has
// issued the row's last result, as the single row buffer is read while results stream.
// Reset: counts, queue and sequencer clear at once; the buffers need no clearing
// pass. Configuration returns to begin/end not given, step 1, list mode.
module strided_slice_extractor_top #(
  parameter int MAX_ELEMS  = ssx_pkg::MAX_ELEMS_DEF,
  parameter int ELEM_WIDTH = ssx_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ssx_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  output ssx_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [ssx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssx_pkg::OFS_W-1:0]           cfg_wdata
);
  import ssx_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);
  localparam int JW = $bits(job_t);
  localparam int QW = JW + 2 * CW;

  cfg_t                  cfg_r;
  logic                  accept;

  // Front end to buffer and queue
  logic                  elem_we;
  logic [AW-1:0]         elem_waddr;
  logic [ELEM_WIDTH-1:0] elem_wdata;
  logic                  cps_we;
  logic [AW-1:0]         cps_waddr;
  logic [AW-1:0]         cps_wdata;
  logic                  job_push;
  job_t                  job_in;
  logic [CW-1:0]         job_ecnt_in;
  logic [CW-1:0]         job_cpc_in;

  // Queue to back end
  logic [QW-1:0]         q_rdata;
  logic                  q_not_empty;
  logic                  q_full;
  logic                  job_pop;

  // Back end to buffer
  logic                  elem_rd_en;
  logic [AW-1:0]         elem_rd_addr;
  logic [ELEM_WIDTH-1:0] elem_rd_data;
  logic [AW-1:0]         cps_rd_addr0;
  logic [AW-1:0]         cps_rd_addr1;
  logic [AW-1:0]         cps_rd_data0;
  logic [AW-1:0]         cps_rd_data1;
  logic                  back_busy;

  // Hold off new transactions while a closed row waits or is being sliced
  assign busy   = q_not_empty || back_busy;
  assign accept = start && !busy;

  // Configuration registers; the user must write them only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{begin_offset: '0, begin_given: 1'b0, end_offset: '0,
                 end_given: 1'b0, step: 17'sd1, utf8_mode: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BEGIN_OFFSET: cfg_r.begin_offset <= cfg_wdata;
        CFG_BEGIN_GIVEN:  cfg_r.begin_given  <= cfg_wdata[0];
        CFG_END_OFFSET:   cfg_r.end_offset   <= cfg_wdata;
        CFG_END_GIVEN:    cfg_r.end_given    <= cfg_wdata[0];
        CFG_STEP:         cfg_r.step         <= cfg_wdata;
        CFG_UTF8_MODE:    cfg_r.utf8_mode    <= cfg_wdata[0];
        default: begin
          // drop writes to indexes beyond the register list
        end
      endcase
    end
  end

  // Front end: load the row, mark code point starts, post a job at row close
  ssx_front #(
    .MAX_ELEMS  (MAX_ELEMS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_item    (in_item),
    .utf8_mode  (cfg_r.utf8_mode),
    .elem_we    (elem_we),
    .elem_waddr (elem_waddr),
    .elem_wdata (elem_wdata),
    .cps_we     (cps_we),
    .cps_waddr  (cps_waddr),
    .cps_wdata  (cps_wdata),
    .job_push   (job_push),
    .job        (job_in),
    .job_ecnt   (job_ecnt_in),
    .job_cpc    (job_cpc_in)
  );

  // Row buffer and code point start table
  ssx_buffer #(
    .MAX_ELEMS  (MAX_ELEMS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_buffer (
    .clk          (clk),
    .elem_we      (elem_we),
    .elem_waddr   (elem_waddr),
    .elem_wdata   (elem_wdata),
    .elem_rd_en   (elem_rd_en),
    .elem_rd_addr (elem_rd_addr),
    .elem_rd_data (elem_rd_data),
    .cps_we       (cps_we),
    .cps_waddr    (cps_waddr),
    .cps_wdata    (cps_wdata),
    .cps_rd_addr0 (cps_rd_addr0),
    .cps_rd_addr1 (cps_rd_addr1),
    .cps_rd_data0 (cps_rd_data0),
    .cps_rd_data1 (cps_rd_data1)
  );

  // Job queue between the two halves: row kind, overflow flag and counts
  ssx_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .wdata     ({job_ecnt_in, job_cpc_in, job_in}),
    .pop       (job_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back end: resolve the slice bounds and stream the selected items out
  ssx_back #(
    .MAX_ELEMS  (MAX_ELEMS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .job_valid    (q_not_empty),
    .job          (q_rdata[JW-1:0]),
    .job_ecnt     (q_rdata[QW-1:QW-CW]),
    .job_cpc      (q_rdata[JW+CW-1:JW]),
    .job_pop      (job_pop),
    .elem_rd_en   (elem_rd_en),
    .elem_rd_addr (elem_rd_addr),
    .elem_rd_data (elem_rd_data),
    .cps_rd_addr0 (cps_rd_addr0),
    .cps_rd_addr1 (cps_rd_addr1),
    .cps_rd_data0 (cps_rd_data0),
    .cps_rd_data1 (cps_rd_data1),
    .back_busy    (back_busy),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

  // A closing transaction must hold the input off: busy is high after it
  a_close_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.cmd == CMD_EMPTY || in_item.cmd == CMD_NULL ||
                (in_item.cmd == CMD_ELEM && in_item.row_end))) |=> busy)
    else $error("row closed but input not held off");

  a_null_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.null_result) |->
      (out_item.out_last && !out_item.slice_empty && out_item.out_value == '0))
    else $error("null result not a lone final result");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !q_full)
    else $error("transaction taken with the job queue full");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import ssx_pkg::*;

  localparam int ROW_CAP      = MAX_ELEMS_DEF;
  localparam int RANDOM_ITEMS = 300;
  localparam int SETTLE       = 8;      // back-end latency margin before a register write
  localparam int RUN_LIMIT_NS = 3_000_000;

  // Clock, reset and the block's inputs, all known from time zero
  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  in_item_t    in_item = '0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFS_W-1:0]     cfg_wdata = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_item;

  strided_slice_extractor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #(RUN_LIMIT_NS);
    $display("strided_slice_extractor_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Slice predictor: shadow registers, row buffer and the expected result queue
  // ---------------------------------------------------------------------------
  int          slice_begin, slice_end, slice_step;
  bit          begin_set, end_set, string_mode;
  logic [31:0] row_elems [ROW_CAP];
  int          cp_first [ROW_CAP + 1];
  int          elem_total, cp_total;
  bit          row_truncated;
  out_item_t   slice_results_q [$];
  int          mismatch_count;

  // One result is held back so that the row's final one can take out_last
  logic [31:0] staged_value;
  bit          staged_valid;

  bit          sender_idles = 1'b1;

  function automatic void clear_row();
    elem_total    = 0;
    cp_total      = 0;
    row_truncated = 1'b0;
  endfunction

  function automatic void post_result(logic [31:0] v, bit last, bit empty, bit nul);
    out_item_t r;
    r.out_value   = v;
    r.out_last    = last;
    r.slice_empty = empty;
    r.null_result = nul;
    r.truncated   = row_truncated;
    slice_results_q = {slice_results_q, r};
  endfunction

  function automatic void stage(logic [31:0] v);
    if (staged_valid) post_result(staged_value, 1'b0, 1'b0, 1'b0);
    staged_value = v;
    staged_valid = 1'b1;
  endfunction

  // Select one index: an element in list mode, all bytes of a code point otherwise
  function automatic void select_index(int idx);
    int from, upto;
    if (!string_mode) begin
      if (idx >= 0 && idx < elem_total) stage(row_elems[idx]);
      return;
    end
    if (idx < 0 || idx >= cp_total) return;
    from = cp_first[idx];
    upto = (idx + 1 < cp_total) ? cp_first[idx + 1] : elem_total;
    for (int b = from; b < upto && b < ROW_CAP; b++) stage(row_elems[b]);
  endfunction

  function automatic void close_row();
    int len, lo, hi;
    // Zero stride, or a backward walk over a string, has no defined result
    if (slice_step == 0 || (string_mode && slice_step < 0)) begin
      post_result('0, 1'b1, 1'b0, 1'b1);
      clear_row();
      return;
    end
    len = string_mode ? cp_total : elem_total;
    lo  = begin_set ? slice_begin : 0;
    hi  = end_set ? slice_end : len;
    if (lo < 0) lo += len;
    if (hi < 0) hi += len;
    if (lo < 0) lo = 0;
    if (lo > len) lo = len;
    if (hi < 0) hi = 0;
    if (hi > len) hi = len;
    staged_valid = 1'b0;
    if (hi > lo) begin
      if (slice_step > 0) begin
        for (int i = lo; i < hi; i += slice_step) select_index(i);
      end else begin
        for (int i = hi - 1; i >= lo; i += slice_step) select_index(i);
      end
    end
    if (staged_valid) post_result(staged_value, 1'b1, 1'b0, 1'b0);
    else              post_result('0, 1'b1, 1'b1, 1'b0);
    clear_row();
  endfunction

  // Advance the predictor by one accepted input transaction
  function automatic void take_item(in_item_t it);
    logic [31:0] v;
    case (it.cmd)
      CMD_UNUSED: ;
      CMD_NULL: begin
        clear_row();
        post_result('0, 1'b1, 1'b0, 1'b1);
      end
      CMD_EMPTY: begin
        clear_row();
        close_row();
      end
      default: begin
        if (elem_total < ROW_CAP) begin
          v = it.item_value;
          if (string_mode) begin
            v = {24'd0, it.item_value[7:0]};
            if ((v[7:0] & CONT_MASK) != CONT_CODE && cp_total < ROW_CAP) begin
              cp_first[cp_total] = elem_total;
              cp_total++;
            end
          end
          row_elems[elem_total] = v;
          elem_total++;
        end else begin
          row_truncated = 1'b1;
        end
        if (it.row_end) close_row();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: results cannot be held off, so take every strobed one
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(string what, out_item_t want, out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected value=%h last=%b empty=%b null=%b trunc=%b",
               want.out_value, want.out_last, want.slice_empty, want.null_result,
               want.truncated);
      $display("  actual   value=%h last=%b empty=%b null=%b trunc=%b",
               got.out_value, got.out_last, got.slice_empty, got.null_result,
               got.truncated);
    end
  endfunction

  // Sample mid-cycle: the strobe holds for the whole cycle up to its accepting edge
  always @(negedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (slice_results_q.size() == 0) begin
        flag_mismatch("result transaction with nothing expected", '0, out_item);
      end else begin
        want = slice_results_q.pop_front();
        if (out_item.out_value   !== want.out_value   ||
            out_item.out_last    !== want.out_last    ||
            out_item.slice_empty !== want.slice_empty ||
            out_item.null_result !== want.null_result ||
            out_item.truncated   !== want.truncated)
          flag_mismatch("result transaction differs", want, out_item);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: every task is entered and left in the time step of a rising edge
  // ---------------------------------------------------------------------------

  // Send one input transaction; hold start high across back-to-back items
  task automatic send_item(cmd_t c, logic [31:0] v, bit row_end);
    in_item_t it;
    int gap;
    it.cmd        = c;
    it.item_value = v;
    it.row_end    = row_end;
    // Toggle between idling stretches and full-rate stretches now and then
    if ($urandom_range(0, 19) == 0) sender_idles = !sender_idles;
    gap = sender_idles ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    // busy seen mid-cycle is what the next edge will see
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    take_item(it);
  endtask

  // Drop start, let every expected result arrive and the back end go quiet
  task automatic drain_results();
    start <= 1'b0;
    while (slice_results_q.size() != 0) @(posedge clk);
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t r, int v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v[OFS_W-1:0];
    @(posedge clk);
  endtask

  // Write all six registers back to back, then update the shadow copy
  task automatic apply_config(int b, bit bg, int e, bit eg, int s, bit u);
    put_reg(CFG_BEGIN_OFFSET, b);
    put_reg(CFG_BEGIN_GIVEN, int'(bg));
    put_reg(CFG_END_OFFSET, e);
    put_reg(CFG_END_GIVEN, int'(eg));
    put_reg(CFG_STEP, s);
    put_reg(CFG_UTF8_MODE, int'(u));
    cfg_we      <= 1'b0;
    slice_begin = b;
    begin_set   = bg;
    slice_end   = e;
    end_set     = eg;
    slice_step  = s;
    string_mode = u;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset configuration: whole row forward, value extremes
  task automatic test_default_row();
    send_item(CMD_ELEM, 32'h0000_0000, 1'b0);
    send_item(CMD_ELEM, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_ELEM, 32'h5A5A_A5A5, 1'b1);
    drain_results();
  endtask

  // Empty row, null row over a partial row, unused code ignored mid-row
  task automatic test_row_commands();
    send_item(CMD_EMPTY, 32'h0000_0011, 1'b1);
    send_item(CMD_ELEM, 32'h0000_0001, 1'b0);
    send_item(CMD_NULL, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_ELEM, 32'h0000_0007, 1'b0);
    send_item(CMD_UNUSED, 32'hAAAA_5555, 1'b1);
    send_item(CMD_ELEM, 32'h0000_0008, 1'b1);
    drain_results();
  endtask

  // Stride error and bound/stride extremes in list mode
  task automatic test_list_bounds();
    apply_config(0, 1'b0, 0, 1'b0, 0, 1'b0);
    send_item(CMD_ELEM, 32'h0000_0003, 1'b1);
    drain_results();
    // Widest window walked backward with the largest negative stride
    apply_config(-65536, 1'b1, 65535, 1'b1, -65536, 1'b0);
    send_item(CMD_ELEM, 32'h1111_1111, 1'b0);
    send_item(CMD_ELEM, 32'h2222_2222, 1'b1);
    drain_results();
    // Begin past the end: nothing selected
    apply_config(65535, 1'b1, -65536, 1'b1, 65535, 1'b0);
    send_item(CMD_ELEM, 32'h3333_3333, 1'b1);
    drain_results();
  endtask

  // Code point slicing, a stray leading continuation byte, backward string stride
  task automatic test_string_slices();
    apply_config(-2, 1'b1, 0, 1'b0, 1, 1'b1);
    send_item(CMD_ELEM, 32'hFFFF_FF80, 1'b0);
    send_item(CMD_ELEM, 32'h1234_5661, 1'b0);
    send_item(CMD_ELEM, 32'h0000_00C3, 1'b0);
    send_item(CMD_ELEM, 32'hABCD_EFA9, 1'b0);
    send_item(CMD_ELEM, 32'h0000_00E2, 1'b0);
    send_item(CMD_ELEM, 32'h8000_0082, 1'b0);
    send_item(CMD_ELEM, 32'h0000_00AC, 1'b1);
    drain_results();
    apply_config(0, 1'b0, 0, 1'b0, -1, 1'b1);
    send_item(CMD_ELEM, 32'h0000_0041, 1'b1);
    drain_results();
  endtask

  // Mode switched while a row is half loaded: marks already recorded stand
  task automatic test_mode_switch();
    apply_config(0, 1'b0, 0, 1'b0, 1, 1'b1);
    send_item(CMD_ELEM, 32'h0000_00C3, 1'b0);
    drain_results();
    apply_config(0, 1'b0, 0, 1'b0, 1, 1'b0);
    send_item(CMD_ELEM, 32'h1234_5678, 1'b0);
    send_item(CMD_ELEM, 32'hDEAD_BEEF, 1'b1);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Random rows
  // ---------------------------------------------------------------------------
  function automatic int pick_offset();
    case ($urandom_range(0, 9))
      0:       return -65536;
      1:       return 65535;
      2:       return int'($urandom_range(0, 131071)) - 65536;
      default: return int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic int pick_step(bit strings);
    int s;
    case ($urandom_range(0, 15))
      0:       s = 0;
      1:       s = -65536;
      2:       s = 65535;
      3:       s = int'($urandom_range(0, 131071)) - 65536;
      default: begin
        s = int'($urandom_range(1, 4));
        // Mostly forward in string mode, else most rows would be null
        if ($urandom_range(0, strings ? 7 : 2) == 0) s = -s;
      end
    endcase
    return s;
  endfunction

  // Send len elements; mostly well-formed UTF-8 in string mode, some raw noise
  task automatic send_row(int len, bit close, inout int sent);
    logic [31:0] v;
    logic [7:0]  byte_val;
    int          cont_left;
    int          sz;
    cont_left = 0;
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 11) == 0)
        send_item(CMD_UNUSED, $urandom, 1'($urandom_range(0, 1)));
      v = $urandom;
      if (string_mode) begin
        if ($urandom_range(0, 9) == 0) begin
          byte_val = 8'($urandom);
        end else if (cont_left > 0) begin
          byte_val  = 8'h80 | 8'($urandom_range(0, 63));
          cont_left--;
        end else begin
          sz = $urandom_range(1, 4);
          case (sz)
            1:       byte_val = 8'($urandom_range(0, 127));
            2:       byte_val = 8'hC0 | 8'($urandom_range(0, 31));
            3:       byte_val = 8'hE0 | 8'($urandom_range(0, 15));
            default: byte_val = 8'hF0 | 8'($urandom_range(0, 7));
          endcase
          cont_left = sz - 1;
        end
        v[7:0] = byte_val;
      end
      send_item(CMD_ELEM, v, close && (n == len - 1));
      sent++;
    end
  endtask

  task automatic test_random_rows();
    int sent, rows, kind, len;
    bit u;
    sent = 0;
    rows = 0;
    while (sent < RANDOM_ITEMS) begin
      // New configuration every few rows, only once the block is quiet
      if (rows % 3 == 0) begin
        drain_results();
        u = 1'($urandom_range(0, 1));
        apply_config(pick_offset(), $urandom_range(0, 3) != 0,
                     pick_offset(), $urandom_range(0, 3) != 0, pick_step(u), u);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9:  len = $urandom_range(1, 8);
        10, 11, 12, 13:                len = $urandom_range(9, 30);
        14:                            len = $urandom_range(40, 64);
        default:                       len = $urandom_range(1, 6);
      endcase
      // Force a few rows past the buffer so truncation is exercised
      if (rows == 2 || rows == 9 || rows == 17) len = $urandom_range(65, 72);
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        send_row(len, 1'b1, sent);
      end else if (kind < 17) begin
        send_item(CMD_EMPTY, $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else if (kind == 17) begin
        send_item(CMD_NULL, $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        // Broken row: a partial row cut off by a null or empty command
        send_row($urandom_range(1, 5), 1'b0, sent);
        send_item(kind == 18 ? CMD_NULL : CMD_EMPTY, $urandom, 1'b0);
        sent++;
      end
      rows++;
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    staged_valid   = 1'b0;
    staged_value   = '0;
    clear_row();
    // Shadow registers start from the block's reset values
    slice_begin = 0;
    begin_set   = 1'b0;
    slice_end   = 0;
    end_set     = 1'b0;
    slice_step  = 1;
    string_mode = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_row();
    test_row_commands();
    test_list_bounds();
    test_string_slices();
    test_mode_switch();
    test_random_rows();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && slice_results_q.size() == 0)
      $display("strided_slice_extractor_top: match");
    else
      $display("strided_slice_extractor_top: mismatch");
    $finish;
  end

endmodule

// File: strided_slice_extractor_top.f
src/ssx_pkg.sv
src/ssx_buffer.sv
src/ssx_front.sv
src/ssx_queue.sv
src/ssx_back.sv
src/strided_slice_extractor_top.sv
bench/tb.sv
